// File: sv/cst_pkg.sv
`default_nettype none

package cst_pkg;

  localparam int AddrW = 48;
  localparam int GenW  = 64;
  localparam int TimeW = 64;

  // Commands
  localparam logic [2:0] CMD_APPLY     = 3'd0;
  localparam logic [2:0] CMD_APPLY_GEN = 3'd1;
  localparam logic [2:0] CMD_ABORT     = 3'd2;
  localparam logic [2:0] CMD_PICK      = 3'd3;
  localparam logic [2:0] CMD_PREEMPT   = 3'd4;

  // Event types
  localparam logic [2:0] EVT_PREVIEW   = 3'd0;
  localparam logic [2:0] EVT_INCOMING  = 3'd1;
  localparam logic [2:0] EVT_ESTABLISH = 3'd2;
  localparam logic [2:0] EVT_HANGUP    = 3'd3;
  localparam logic [2:0] EVT_UNLOCK    = 3'd4;

  // Session states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PREVIEW = 3'd1;
  localparam logic [2:0] ST_RINGING = 3'd2;
  localparam logic [2:0] ST_TALKING = 3'd3;
  localparam logic [2:0] ST_ENDED   = 3'd4;

  // Result event kinds
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_HANGUP   = 2'd1;
  localparam logic [1:0] KIND_INCOMING = 2'd2;

  // Pick frame constants
  localparam logic [7:0]  PICK_FAMILY     = 8'd3;
  localparam logic [7:0]  PICK_OP_LOCAL   = 8'h03;
  localparam logic [7:0]  PICK_OP_PEER    = 8'h83;
  localparam logic [15:0] PICK_PAYLOAD_LEN = 16'd7;

  localparam logic        STATUS_OK      = 1'b0;
  localparam logic        STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [2:0]       command;
    logic [2:0]       event_type;
    logic [GenW-1:0]  expected_gen;
    logic [AddrW-1:0] source_addr;
    logic [AddrW-1:0] dest_addr;
    logic [AddrW-1:0] local_addr;
    logic [7:0]       frame_family;
    logic [7:0]       frame_opcode;
    logic [15:0]      payload_len;
    logic [TimeW-1:0] now_time;
    logic [TimeW-1:0] window_len;
    logic             preempt_allowed;
  } item_t;

  typedef struct packed {
    logic [2:0]       state;
    logic [GenW-1:0]  gen;
    logic [AddrW-1:0] peer;
    logic [GenW-1:0]  pick_gen;
    logic [TimeW-1:0] pick_start;
    logic [TimeW-1:0] pick_window;
    logic [AddrW-1:0] pick_addr;
  } sess_t;

  // One record per input item; a successful preempt record expands to two transfers.
  typedef struct packed {
    logic             status;
    logic             ended;
    logic [2:0]       state_now;
    logic [GenW-1:0]  gen_now;
    logic             pair;
    logic [AddrW-1:0] old_peer;
    logic [GenW-1:0]  old_gen;
    logic [AddrW-1:0] new_peer;
    logic [TimeW-1:0] ring;
  } rec_t;

endpackage

`default_nettype wire

// File: sv/cst_step.sv
`default_nettype none

module cst_step (
  input  cst_pkg::item_t item_i,
  input  cst_pkg::sess_t sess_i,
  output cst_pkg::sess_t sess_o,
  output cst_pkg::rec_t  rec_o
);
  import cst_pkg::*;

  logic            active;
  logic            dormant;
  logic            in_win;
  logic [TimeW-1:0] elapsed;
  logic [GenW-1:0] gen_inc;
  logic [GenW-1:0] gen_begin;
  logic            gen_match;
  logic            ok;
  logic            ended;
  logic            pair;
  logic            apply_ok;
  sess_t           apply_s;
  sess_t           nxt;

  always_comb begin
    active    = sess_i.state inside {ST_PREVIEW, ST_RINGING, ST_TALKING};
    dormant   = (sess_i.state == ST_IDLE) || (sess_i.state == ST_ENDED);
    elapsed   = item_i.now_time - sess_i.pick_start;
    in_win    = (item_i.now_time >= sess_i.pick_start) && (elapsed < sess_i.pick_window);
    gen_inc   = sess_i.gen + GenW'(1);
    gen_begin = (gen_inc == '0) ? GenW'(1) : gen_inc;
    gen_match = (item_i.expected_gen != '0) && (item_i.expected_gen == sess_i.gen);
  end

  // Event application, shared by plain and generation-checked apply.
  always_comb begin
    apply_s  = sess_i;
    apply_ok = 1'b0;
    if (active && (sess_i.peer != item_i.source_addr)) begin
      apply_ok = 1'b0;
    end else if (dormant && (item_i.event_type == EVT_PREVIEW ||
                             item_i.event_type == EVT_INCOMING)) begin
      apply_ok         = 1'b1;
      apply_s.gen      = gen_begin;
      apply_s.pick_gen = '0;
      apply_s.peer     = item_i.source_addr;
      apply_s.state    = (item_i.event_type == EVT_PREVIEW) ? ST_PREVIEW : ST_RINGING;
    end else if ((sess_i.state == ST_PREVIEW || sess_i.state == ST_RINGING) &&
                 item_i.event_type == EVT_ESTABLISH) begin
      apply_ok      = 1'b1;
      apply_s.state = ST_TALKING;
    end else if (active && item_i.event_type == EVT_HANGUP) begin
      apply_ok         = 1'b1;
      apply_s.state    = ST_ENDED;
      apply_s.pick_gen = '0;
    end else if (sess_i.state == ST_RINGING && item_i.event_type == EVT_INCOMING) begin
      apply_ok = 1'b1;
    end else if (active && item_i.event_type == EVT_UNLOCK) begin
      apply_ok = 1'b1;
    end
  end

  always_comb begin
    nxt   = sess_i;
    ok    = 1'b0;
    ended = 1'b0;
    pair  = 1'b0;
    case (item_i.command)
      CMD_APPLY: begin
        ok  = apply_ok;
        nxt = apply_s;
      end
      CMD_APPLY_GEN: begin
        if (gen_match) begin
          ok  = apply_ok;
          nxt = apply_s;
        end
      end
      CMD_ABORT: begin
        ok = 1'b1;
        if (active) begin
          ended           = 1'b1;
          nxt.state       = ST_ENDED;
          nxt.pick_gen    = '0;
          nxt.pick_start  = '0;
          nxt.pick_window = '0;
          nxt.pick_addr   = '0;
        end
      end
      CMD_PICK: begin
        if (item_i.window_len != '0 && sess_i.gen != '0 &&
            (sess_i.state == ST_RINGING || sess_i.state == ST_PREVIEW) &&
            item_i.frame_family == PICK_FAMILY &&
            item_i.payload_len == PICK_PAYLOAD_LEN) begin
          if (item_i.frame_opcode == PICK_OP_LOCAL) begin
            if (item_i.source_addr == item_i.local_addr &&
                item_i.dest_addr == sess_i.peer) begin
              if (sess_i.pick_gen == sess_i.gen) begin
                // retransmission: the original window stands
                ok = in_win;
              end else begin
                ok              = 1'b1;
                nxt.pick_gen    = sess_i.gen;
                nxt.pick_start  = item_i.now_time;
                nxt.pick_window = item_i.window_len;
                nxt.pick_addr   = item_i.local_addr;
              end
            end
          end else if (item_i.frame_opcode == PICK_OP_PEER &&
                       item_i.source_addr == sess_i.peer &&
                       item_i.dest_addr == item_i.local_addr &&
                       sess_i.pick_addr == item_i.local_addr &&
                       sess_i.pick_gen == sess_i.gen) begin
            nxt.pick_gen = '0;
            if (in_win) begin
              ok        = 1'b1;
              nxt.state = ST_TALKING;
            end
          end
        end
      end
      CMD_PREEMPT: begin
        if (sess_i.state == ST_RINGING && gen_match && sess_i.gen != '1 &&
            sess_i.peer != item_i.source_addr && item_i.preempt_allowed) begin
          ok              = 1'b1;
          pair            = 1'b1;
          nxt.peer        = item_i.source_addr;
          nxt.gen         = gen_inc;
          nxt.pick_gen    = '0;
          nxt.pick_start  = '0;
          nxt.pick_window = '0;
          nxt.pick_addr   = '0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign sess_o = nxt;

  always_comb begin
    rec_o.status    = ok ? STATUS_OK : STATUS_INVALID;
    rec_o.ended     = ended;
    rec_o.state_now = nxt.state;
    rec_o.gen_now   = nxt.gen;
    rec_o.pair      = pair;
    rec_o.old_peer  = sess_i.peer;
    rec_o.old_gen   = sess_i.gen;
    rec_o.new_peer  = item_i.source_addr;
    rec_o.ring      = item_i.now_time;
  end

endmodule

`default_nettype wire

// File: sv/cst_out.sv
`default_nettype none

module cst_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  cst_pkg::rec_t                rec_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic                         ended_flag_o,
  output logic [2:0]                   state_now_o,
  output logic [cst_pkg::GenW-1:0]     gen_now_o,
  output logic [1:0]                   event_kind_o,
  output logic [cst_pkg::AddrW-1:0]    event_peer_o,
  output logic [cst_pkg::GenW-1:0]     event_gen_o,
  output logic [cst_pkg::TimeW-1:0]    ring_start_o,
  output logic                         last_o
);
  import cst_pkg::*;

  rec_t rec_q;
  logic vld_q;
  logic beat_q;
  logic pop;
  logic done;

  assign pop     = vld_q && !out_stall_i;
  assign done    = pop && (!rec_q.pair || beat_q);
  assign ready_o = !vld_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= 1'b0;
    end else if (load_i) begin
      vld_q  <= 1'b1;
      beat_q <= 1'b0;
    end else if (done) begin
      vld_q  <= 1'b0;
      beat_q <= 1'b0;
    end else if (pop) begin
      beat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  always_comb begin
    out_valid_o  = vld_q;
    status_o     = rec_q.status;
    ended_flag_o = rec_q.ended;
    state_now_o  = rec_q.state_now;
    gen_now_o    = rec_q.gen_now;
    last_o       = !rec_q.pair || beat_q;
    if (rec_q.pair) begin
      event_kind_o = beat_q ? KIND_INCOMING : KIND_HANGUP;
      event_peer_o = beat_q ? rec_q.new_peer : rec_q.old_peer;
      event_gen_o  = beat_q ? rec_q.gen_now : rec_q.old_gen;
      ring_start_o = rec_q.ring;
    end else begin
      event_kind_o = KIND_NONE;
      event_peer_o = '0;
      event_gen_o  = '0;
      ring_start_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: sv/call_session_tracker_core.sv
// Call session tracker: follows one intercom call through idle, preview,
// ringing, talking and ended, with its generation, peer and pick window.
//
// Input channel: in_valid_i / in_stall_o with one port per command field.
// An item transfers at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i; a transfer happens with
// out_valid_o high and out_stall_i low. last_o marks the final result of
// an item.
//
// An item lands in the input register; once the result register can take it,
// the step logic updates the session registers and loads the result register
// on the same edge, and its first result shows from the result register.
// Throughput: one item per cycle while the receiver does not stall. A
// successful preempt yields two results (hangup, then incoming call) from one
// result register, which holds the input side until the second result
// transfers; the result register is the limit.
// When the receiver stalls, the result register holds its value; the input
// register takes one more item only if it is empty, then in_stall_o rises.
// Reset clears the session to idle with generation, peer and pick window zero.
`default_nettype none

module call_session_tracker_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic [2:0]                   event_type_i,
  input  logic [cst_pkg::GenW-1:0]     expected_gen_i,
  input  logic [cst_pkg::AddrW-1:0]    source_addr_i,
  input  logic [cst_pkg::AddrW-1:0]    dest_addr_i,
  input  logic [cst_pkg::AddrW-1:0]    local_addr_i,
  input  logic [7:0]                   frame_family_i,
  input  logic [7:0]                   frame_opcode_i,
  input  logic [15:0]                  payload_len_i,
  input  logic [cst_pkg::TimeW-1:0]    now_time_i,
  input  logic [cst_pkg::TimeW-1:0]    window_len_i,
  input  logic                         preempt_allowed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic                         ended_flag_o,
  output logic [2:0]                   state_now_o,
  output logic [cst_pkg::GenW-1:0]     gen_now_o,
  output logic [1:0]                   event_kind_o,
  output logic [cst_pkg::AddrW-1:0]    event_peer_o,
  output logic [cst_pkg::GenW-1:0]     event_gen_o,
  output logic [cst_pkg::TimeW-1:0]    ring_start_o,
  output logic                         last_o
);
  import cst_pkg::*;

  item_t item_q;
  logic  in_vld_q;
  sess_t sess_q;
  sess_t sess_d;
  rec_t  rec;
  logic  out_ready;
  logic  advance;

  // Advance the held item once the result register can take it.
  assign advance    = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.command         <= command_i;
      item_q.event_type      <= event_type_i;
      item_q.expected_gen    <= expected_gen_i;
      item_q.source_addr     <= source_addr_i;
      item_q.dest_addr       <= dest_addr_i;
      item_q.local_addr      <= local_addr_i;
      item_q.frame_family    <= frame_family_i;
      item_q.frame_opcode    <= frame_opcode_i;
      item_q.payload_len     <= payload_len_i;
      item_q.now_time        <= now_time_i;
      item_q.window_len      <= window_len_i;
      item_q.preempt_allowed <= preempt_allowed_i;
    end
  end

  cst_step u_step (
    .item_i (item_q),
    .sess_i (sess_q),
    .sess_o (sess_d),
    .rec_o  (rec)
  );

  // Commit the session update together with the result load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q.state       <= ST_IDLE;
      sess_q.gen         <= '0;
      sess_q.peer        <= '0;
      sess_q.pick_gen    <= '0;
      sess_q.pick_start  <= '0;
      sess_q.pick_window <= '0;
      sess_q.pick_addr   <= '0;
    end else if (advance) begin
      sess_q <= sess_d;
    end
  end

  cst_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .rec_i        (rec),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .ended_flag_o (ended_flag_o),
    .state_now_o  (state_now_o),
    .gen_now_o    (gen_now_o),
    .event_kind_o (event_kind_o),
    .event_peer_o (event_peer_o),
    .event_gen_o  (event_gen_o),
    .ring_start_o (ring_start_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // A hangup result of a preempt is always followed by its incoming-call result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (event_kind_o == KIND_INCOMING) && last_o)
    else $error("preempt second result missing");

  // Any session that has left idle carries a nonzero generation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sess_q.state != ST_IDLE) |-> (sess_q.gen != '0))
    else $error("active or ended session with zero generation");

  // A session update only happens when its result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(sess_q))
    else $error("session changed without an item");
`endif

endmodule

`default_nettype wire
